// ===== rtl/core/sorted_table_key_search_defines.svh =====
// assertion macros for the sorted table key search core
`ifndef SORTED_TABLE_KEY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_KEY_SEARCH_DEFINES_SVH

// same-cycle implication
`define STKS_ASSERT_IMP(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("sorted_table_key_search: assertion failed");

// next-cycle implication
`define STKS_ASSERT_NXT(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("sorted_table_key_search: assertion failed");

`endif

// ===== rtl/core/stks_pkg.sv =====
// shared types, constants and command/status structs for the key search core
package stks_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int POS_W       = ((CFG_W > CNT_W) ? CFG_W : CNT_W) + 2;

    localparam int MODE_W      = 2;
    localparam int SLOT_W      = 10;
    localparam int KEY_W       = 32;
    localparam int POSITION_W  = 10;

    localparam int S_TDATA_W   = ((SLOT_W + KEY_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((POSITION_W + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD   = 2'd0,
        MODE_BINARY = 2'd1,
        MODE_JUMP   = 2'd2,
        MODE_LINEAR = 2'd3
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_STEP   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIN_ISSUE,
        ST_BIN_CMP,
        ST_JUMP_ISSUE,
        ST_JUMP_CMP,
        ST_SCAN_START,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef logic signed [POS_W-1:0] pos_t;

    typedef struct packed {
        logic load_wr;
        logic take_key;
        logic range_init;
        logic jump_init;
        logic bin_issue;
        logic bin_update;
        logic jump_probe;
        logic jump_advance;
        logic jump_window;
        logic scan_start;
        logic scan_step;
        logic set_found_mid;
        logic set_found_chk;
        logic set_miss;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic bin_empty;
        logic jump_in;
        logic match;
        logic less;
        logic chk_vld;
    } status_t;

endpackage

// ===== rtl/core/stks_ram.sv =====
// generic single-write, single-read ram with registered read data
module stks_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/stks_ctrl.sv =====
// controller state machine for the key search core
module stks_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  stks_pkg::mode_t   s_mode,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  stks_pkg::status_t status,
    output stks_pkg::cmd_t    cmd
);
    import stks_pkg::*;

    state_t state_reg, state_next;
    logic   out_vld_reg, out_vld_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (s_mode)
                        MODE_LOAD: begin
                            cmd.load_wr = 1'b1;
                        end
                        MODE_BINARY: begin
                            cmd.take_key   = 1'b1;
                            cmd.range_init = 1'b1;
                            state_next     = ST_BIN_ISSUE;
                        end
                        MODE_JUMP: begin
                            cmd.take_key  = 1'b1;
                            cmd.jump_init = 1'b1;
                            state_next    = ST_JUMP_ISSUE;
                        end
                        MODE_LINEAR: begin
                            cmd.take_key   = 1'b1;
                            cmd.range_init = 1'b1;
                            state_next     = ST_SCAN_START;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_BIN_ISSUE: begin
                if (status.bin_empty) begin
                    cmd.set_miss = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    cmd.bin_issue = 1'b1;
                    state_next    = ST_BIN_CMP;
                end
            end
            ST_BIN_CMP: begin
                if (status.match) begin
                    cmd.set_found_mid = 1'b1;
                    state_next        = ST_DONE;
                end else begin
                    cmd.bin_update = 1'b1;
                    state_next     = ST_BIN_ISSUE;
                end
            end
            ST_JUMP_ISSUE: begin
                if (status.jump_in) begin
                    cmd.jump_probe = 1'b1;
                    state_next     = ST_JUMP_CMP;
                end else begin
                    cmd.jump_window = 1'b1;
                    state_next      = ST_SCAN_START;
                end
            end
            ST_JUMP_CMP: begin
                if (status.less) begin
                    cmd.jump_advance = 1'b1;
                    state_next       = ST_JUMP_ISSUE;
                end else begin
                    cmd.jump_window = 1'b1;
                    state_next      = ST_SCAN_START;
                end
            end
            ST_SCAN_START: begin
                cmd.scan_start = 1'b1;
                state_next     = ST_SCAN;
            end
            ST_SCAN: begin
                if (status.chk_vld && status.match) begin
                    cmd.set_found_chk = 1'b1;
                    state_next        = ST_DONE;
                end else if (!status.chk_vld) begin
                    cmd.set_miss = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_DONE: begin
                if (!out_vld_reg || m_tready) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.commit) begin
            out_vld_next = 1'b1;
        end else if (out_vld_reg && m_tready) begin
            out_vld_next = 1'b0;
        end else begin
            out_vld_next = out_vld_reg;
        end
    end

    assign m_tvalid = out_vld_reg;

endmodule

// ===== rtl/core/stks_dp.sv =====
// datapath: config registers, key table, search pointers and result registers
module stks_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [stks_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [stks_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic [stks_pkg::SLOT_W-1:0]         s_slot,
    input  logic [stks_pkg::KEY_W-1:0]          s_key,
    input  stks_pkg::cmd_t                      cmd,
    output stks_pkg::status_t                   status,
    output logic                                m_found,
    output logic [stks_pkg::POSITION_W-1:0]     m_position
);
    import stks_pkg::*;

    localparam int SLOT_CMP_W = ((SLOT_W > ADDR_W) ? SLOT_W : ADDR_W) + 1;

    logic [CFG_W-1:0]      entry_count_reg;
    logic [CFG_W-1:0]      jump_step_reg;
    logic [KEY_W-1:0]      key_reg;
    pos_t                  lo_reg, hi_reg, i_reg, mid_reg, cur_reg, chk_reg;
    logic                  chk_vld_reg;
    logic                  res_found_reg;
    logic [POSITION_W-1:0] res_pos_reg;
    logic                  m_found_reg;
    logic [POSITION_W-1:0] m_pos_reg;

    logic [CFG_W-1:0]      step_u;
    pos_t                  n_s, step_s, mid_w, diff_w, win_lo, win_hi, rd_pos;
    logic signed [POS_W:0] mid_sum;
    logic [ADDR_W-1:0]     rd_addr;
    logic [KEY_W-1:0]      rd_data;
    logic                  wr_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
            jump_step_reg   <= CFG_W'(1);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ENTRY_COUNT: entry_count_reg <= cfg_wdata;
                CFG_JUMP_STEP:   jump_step_reg   <= cfg_wdata;
                default: begin
                    entry_count_reg <= entry_count_reg;
                end
            endcase
        end
    end

    always_comb begin
        if (POS_W'(entry_count_reg) > POS_W'(TABLE_DEPTH)) begin
            n_s = POS_W'(TABLE_DEPTH);
        end else begin
            n_s = POS_W'(entry_count_reg);
        end
        step_u  = (jump_step_reg == '0) ? CFG_W'(1) : jump_step_reg;
        step_s  = POS_W'(step_u);
        mid_sum = (POS_W+1)'(lo_reg) + (POS_W+1)'(hi_reg);
        mid_w   = POS_W'(mid_sum >>> 1);
        diff_w  = i_reg - step_s;
        win_lo  = (diff_w < POS_W'(0)) ? POS_W'(0) : diff_w;
        win_hi  = (i_reg < n_s - POS_W'(1)) ? i_reg : n_s - POS_W'(1);
        if (cmd.bin_issue) begin
            rd_pos = mid_w;
        end else if (cmd.jump_probe) begin
            rd_pos = i_reg;
        end else if (cmd.scan_start) begin
            rd_pos = lo_reg;
        end else begin
            rd_pos = cur_reg;
        end
    end

    assign rd_addr = rd_pos[ADDR_W-1:0];
    assign wr_en   = cmd.load_wr && (SLOT_CMP_W'(s_slot) < SLOT_CMP_W'(TABLE_DEPTH));

    stks_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (ADDR_W'(s_slot)),
        .wdata (s_key),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (cmd.take_key) begin
            key_reg <= s_key;
        end
        if (cmd.range_init) begin
            lo_reg <= '0;
            hi_reg <= n_s - POS_W'(1);
        end
        if (cmd.jump_init) begin
            i_reg <= '0;
        end
        if (cmd.bin_issue) begin
            mid_reg <= mid_w;
        end
        if (cmd.bin_update) begin
            if (status.less) begin
                lo_reg <= mid_reg + POS_W'(1);
            end else begin
                hi_reg <= mid_reg - POS_W'(1);
            end
        end
        if (cmd.jump_advance) begin
            i_reg <= i_reg + step_s;
        end
        if (cmd.jump_window) begin
            lo_reg <= win_lo;
            hi_reg <= win_hi;
        end
        if (cmd.scan_start) begin
            chk_reg     <= lo_reg;
            chk_vld_reg <= (lo_reg <= hi_reg);
            cur_reg     <= lo_reg + POS_W'(1);
        end
        if (cmd.scan_step) begin
            chk_reg     <= cur_reg;
            chk_vld_reg <= (cur_reg <= hi_reg);
            cur_reg     <= cur_reg + POS_W'(1);
        end
        if (cmd.set_found_mid) begin
            res_found_reg <= 1'b1;
            res_pos_reg   <= mid_reg[POSITION_W-1:0];
        end
        if (cmd.set_found_chk) begin
            res_found_reg <= 1'b1;
            res_pos_reg   <= chk_reg[POSITION_W-1:0];
        end
        if (cmd.set_miss) begin
            res_found_reg <= 1'b0;
            res_pos_reg   <= '0;
        end
        if (cmd.commit) begin
            m_found_reg <= res_found_reg;
            m_pos_reg   <= res_pos_reg;
        end
    end

    assign status.bin_empty = (lo_reg > hi_reg);
    assign status.jump_in   = (i_reg < n_s);
    assign status.match     = (rd_data == key_reg);
    assign status.less      = ($signed(rd_data) < $signed(key_reg));
    assign status.chk_vld   = chk_vld_reg;

    assign m_found    = m_found_reg;
    assign m_position = m_pos_reg;

endmodule

// ===== rtl/core/sorted_table_key_search.sv =====
// top level of the sorted table key search core
//
//  channel   direction  handshake            contents
//  s_*       in         s_tvalid / s_tready  load or query request
//  m_*       out        m_tvalid / m_tready  found flag and position per query
//  cfg_*     in         cfg_we               entry_count, jump_step
//
// a load is written from idle; a query allows for the ram's registered read:
// binary issues each probe in ST_BIN_ISSUE and compares it in ST_BIN_CMP,
// linear starts in ST_SCAN_START and checks one slot per ST_SCAN step, jump probes
// by stride in ST_JUMP_ISSUE and ST_JUMP_CMP, then scans a window of up to stride+1 slots.
// reset clears control and config registers only; the table holds no value until loaded.
// a finished result waits in the output register while new requests are taken;
// the next query holds in its last state until that result is taken.
`include "sorted_table_key_search_defines.svh"

module sorted_table_key_search (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [stks_pkg::S_TDATA_W-1:0]     s_tdata,   // slot, key
    input  logic [stks_pkg::MODE_W-1:0]        s_tuser,   // mode
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [stks_pkg::M_TDATA_W-1:0]     m_tdata,   // position
    output logic [0:0]                         m_tuser,   // found
    input  logic                               cfg_we,
    input  logic [stks_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [stks_pkg::CFG_W-1:0]         cfg_wdata
);
    import stks_pkg::*;

    cmd_t                  cmd;
    status_t               status;
    mode_t                 s_mode;
    logic [SLOT_W-1:0]     s_slot;
    logic [KEY_W-1:0]      s_key;
    logic                  m_found;
    logic [POSITION_W-1:0] m_position;

    assign s_mode = mode_t'(s_tuser);
    assign s_slot = s_tdata[SLOT_W-1:0];
    assign s_key  = s_tdata[SLOT_W +: KEY_W];

    stks_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_mode   (s_mode),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    stks_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_slot     (s_slot),
        .s_key      (s_key),
        .cmd        (cmd),
        .status     (status),
        .m_found    (m_found),
        .m_position (m_position)
    );

    assign m_tdata = M_TDATA_W'(m_position);
    assign m_tuser = m_found;

    `STKS_ASSERT_NXT(a_load_no_result, aclk, aresetn, s_tvalid && s_tready && (s_tuser == MODE_LOAD) && !m_tvalid, !m_tvalid)
    `STKS_ASSERT_NXT(a_query_busy, aclk, aresetn, s_tvalid && s_tready && (s_tuser != MODE_LOAD), !s_tready)
    `STKS_ASSERT_IMP(a_miss_pos_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata == '0)

endmodule

// ===== bench/stks_search_checker.sv =====
// checker for the key search core: predicts every query result and compares it
`timescale 1ns / 100ps

module stks_search_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [stks_pkg::S_TDATA_W-1:0]   s_tdata,   // slot, key
    input  logic [stks_pkg::MODE_W-1:0]      s_tuser,   // mode
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [stks_pkg::M_TDATA_W-1:0]   m_tdata,   // position
    input  logic [0:0]                       m_tuser,   // found
    input  logic                             cfg_we,
    input  logic [stks_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [stks_pkg::CFG_W-1:0]       cfg_wdata,
    output int unsigned                      mismatch_count,
    output int unsigned                      awaited_count
);
    import stks_pkg::*;

    typedef struct packed {
        logic                  found;
        logic [POSITION_W-1:0] position;
    } lookup_t;

    logic signed [KEY_W-1:0] key_store [TABLE_DEPTH];
    logic [CFG_W-1:0]        entry_count_q;
    logic [CFG_W-1:0]        jump_step_q;
    lookup_t                 lookup_q [$];
    int unsigned             errors = 0;

    function automatic lookup_t locate_key(input mode_t md, input logic signed [KEY_W-1:0] k);
        int      n;
        int      lo;
        int      hi;
        int      mid;
        int      stride;
        int      i;
        int      j;
        int      pos;
        lookup_t r;
        n   = (entry_count_q > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count_q);
        pos = -1;
        case (md)
            MODE_BINARY: begin
                lo = 0;
                hi = n - 1;
                while (lo <= hi && pos < 0) begin
                    mid = (lo + hi) / 2;
                    if (key_store[mid] == k)
                        pos = mid;
                    else if (key_store[mid] < k)
                        lo = mid + 1;
                    else
                        hi = mid - 1;
                end
            end
            MODE_JUMP: begin
                stride = (jump_step_q == '0) ? 1 : int'(jump_step_q);
                i = 0;
                while (i < n && key_store[i] < k)
                    i += stride;
                lo = (i - stride < 0) ? 0 : i - stride;
                hi = (i < n - 1) ? i : n - 1;
                for (j = lo; j <= hi && pos < 0; j++)
                    if (key_store[j] == k)
                        pos = j;
            end
            default: begin
                for (j = 0; j < n && pos < 0; j++)
                    if (key_store[j] == k)
                        pos = j;
            end
        endcase
        r.found    = (pos >= 0);
        r.position = (pos >= 0) ? pos[POSITION_W-1:0] : '0;
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        lookup_t got;
        lookup_t want;
        if (!aresetn) begin
            entry_count_q = '0;
            jump_step_q   = CFG_W'(1);
            lookup_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_ENTRY_COUNT)
                    entry_count_q = cfg_wdata;
                else if (cfg_index == CFG_JUMP_STEP)
                    jump_step_q = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                if (mode_t'(s_tuser) == MODE_LOAD)
                    key_store[s_tdata[SLOT_W-1:0]] = s_tdata[SLOT_W +: KEY_W];
                else
                    lookup_q.push_back(locate_key(mode_t'(s_tuser), s_tdata[SLOT_W +: KEY_W]));
            end
            if (m_tvalid && m_tready) begin
                got.found    = m_tuser[0];
                got.position = m_tdata[POSITION_W-1:0];
                if (lookup_q.size() == 0) begin
                    $display("%t: unexpected result found %0b position %0d",
                             $time, got.found, got.position);
                    errors++;
                end else begin
                    want = lookup_q.pop_front();
                    if (got.found !== want.found) begin
                        $display("%t: found expected %0b got %0b",
                                 $time, want.found, got.found);
                        errors++;
                    end
                    if (got.position !== want.position) begin
                        $display("%t: position expected %0d got %0d",
                                 $time, want.position, got.position);
                        errors++;
                    end
                end
            end
        end
        mismatch_count <= errors;
        awaited_count  <= lookup_q.size();
    end

endmodule

// ===== bench/tb_sorted_table_key_search.sv =====
// testbench top for the key search core: stimulus, register writes and verdict
`timescale 1ns / 100ps

module tb_sorted_table_key_search;
    import stks_pkg::*;

    localparam int QUIET_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 260;
    localparam int REFILL_MAX    = 40;
    localparam int FULL_FILL     = 256;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    typedef enum int {
        PACE_FREE,
        PACE_SENDER,
        PACE_RECEIVER,
        PACE_BOTH
    } pace_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;   // slot, key
    logic [MODE_W-1:0]      s_tuser   = '0;   // mode
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;          // position
    logic [0:0]             m_tuser;          // found
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;

    int unsigned            mismatches;
    int unsigned            awaited;
    int unsigned            send_gap_pct = 0;
    int unsigned            stall_pct    = 0;
    int unsigned            quiet_cycles = 0;
    int unsigned            loads        = 0;
    int unsigned            queries      = 0;
    int unsigned            settings     = 0;
    logic signed [KEY_W-1:0] table_copy [TABLE_DEPTH];

    sorted_table_key_search i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    stks_search_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatches),
        .awaited_count  (awaited)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("%t: no request or result moved for %0d cycles", $time, QUIET_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic set_pace(input pace_t pace);
        send_gap_pct = (pace == PACE_SENDER) ? 64 : (pace == PACE_BOTH) ? 8 : 0;
        stall_pct    = (pace == PACE_RECEIVER) ? 64 : (pace == PACE_BOTH) ? 8 : 0;
    endtask

    task automatic push_request(input mode_t md, input logic [SLOT_W-1:0] sl,
                                input logic signed [KEY_W-1:0] k);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= md;
        s_tdata  <= S_TDATA_W'({k, sl});
        do @(posedge aclk); while (!s_tready);
        if (md == MODE_LOAD) begin
            table_copy[sl] = k;
            loads++;
        end else begin
            queries++;
        end
    endtask

    task automatic drain();
        @(posedge aclk);
        while (awaited != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [CFG_W-1:0] count, input logic [CFG_W-1:0] stride);
        s_tvalid <= 1'b0;
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ENTRY_COUNT;
        cfg_wdata <= count;
        @(posedge aclk);
        cfg_index <= CFG_JUMP_STEP;
        cfg_wdata <= stride;
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    // mostly keys present in the searched range, some near misses and extremes
    task automatic random_query(input int n);
        logic signed [KEY_W-1:0] k;
        int                      pick;
        pick = $urandom_range(9);
        k    = $urandom;
        if (n > 0 && pick < 6)
            k = table_copy[$urandom_range(n - 1)];
        else if (n > 0 && pick == 6)
            k = table_copy[$urandom_range(n - 1)] + ($urandom_range(1) ? 1 : -1);
        else if (pick == 7)
            k = $urandom_range(1) ? KEY_MIN : KEY_MAX;
        push_request(mode_t'($urandom_range(3, 1)), SLOT_W'($urandom), k);
    endtask

    // a key from the ascending prefix, so the search stops at or before its slot
    task automatic prefix_query();
        int pick;
        pick = $urandom_range(FULL_FILL - 1);
        push_request($urandom_range(1) ? MODE_LINEAR : MODE_JUMP, SLOT_W'($urandom),
                     table_copy[pick]);
    endtask

    initial begin : stimulus
        logic signed [KEY_W-1:0] demo [8];
        logic signed [KEY_W-1:0] k;
        logic [CFG_W-1:0]        count;
        logic [CFG_W-1:0]        stride;
        int                      n;
        int                      root;
        int                      fill;
        int                      sel;
        int                      phase;
        int unsigned             start_items;
        bit                      scrambled;

        set_pace(PACE_FREE);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table right after reset
        push_request(MODE_BINARY, '0, '0);
        push_request(MODE_JUMP, '1, KEY_MAX);
        push_request(MODE_LINEAR, '0, KEY_MIN);

        // short table with both key extremes and duplicate keys
        demo = '{KEY_MIN, -5, -5, 0, 7, 7, 100, KEY_MAX};
        for (int i = 0; i < 8; i++)
            push_request(MODE_LOAD, SLOT_W'(i), demo[i]);
        write_regs(CFG_W'(8), CFG_W'(0));
        push_request(MODE_JUMP, '0, KEY_MIN);
        push_request(MODE_JUMP, '0, KEY_MAX);
        push_request(MODE_JUMP, '0, 7);
        push_request(MODE_BINARY, '0, -5);
        push_request(MODE_BINARY, '0, 7);
        push_request(MODE_BINARY, '0, 50);
        push_request(MODE_LINEAR, '0, KEY_MAX);
        push_request(MODE_LINEAR, '0, -5);
        push_request(MODE_LINEAR, '0, 1);
        write_regs(CFG_W'(8), CFG_W'(3));
        push_request(MODE_JUMP, '0, 100);
        push_request(MODE_JUMP, '0, -6);
        push_request(MODE_BINARY, '0, KEY_MIN);
        push_request(MODE_BINARY, '0, KEY_MAX);

        // ascending prefix, so every later count up to it only reads loaded slots
        set_pace(PACE_BOTH);
        k = KEY_MIN;
        for (int i = 0; i < FULL_FILL; i++) begin
            push_request(MODE_LOAD, SLOT_W'(i), (i == FULL_FILL - 1) ? KEY_MAX : k);
            k = k + (($urandom_range(3) == 0) ? 0 : $urandom_range(4000000, 1));
        end
        write_regs(CFG_W'(FULL_FILL), CFG_W'(16));
        repeat (8) random_query(FULL_FILL);

        // counts at and beyond the table with strides that stop at the match
        set_pace(PACE_RECEIVER);
        write_regs('1, '1);
        repeat (6) prefix_query();
        write_regs(CFG_W'(TABLE_DEPTH), CFG_W'(1));
        repeat (6) prefix_query();

        // refill a prefix with a fresh, sometimes unsorted table, then search it amid stray loads
        phase       = 0;
        start_items = loads + queries;
        while (loads + queries - start_items < RANDOM_ITEMS) begin
            set_pace(pace_t'(phase % 4));
            sel = $urandom_range(9);
            if (sel == 0)
                count = CFG_W'($urandom_range(1));
            else if (sel == 1)
                count = CFG_W'($urandom_range(FULL_FILL));
            else
                count = CFG_W'($urandom_range(REFILL_MAX, 2));
            n   = (count > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);
            sel = $urandom_range(9);
            if (sel == 0) begin
                stride = '0;
            end else if (sel == 1) begin
                stride = '1;
            end else if (sel == 2) begin
                stride = CFG_W'($urandom);
            end else begin
                root = 1;
                while ((root + 1) * (root + 1) <= n)
                    root++;
                stride = CFG_W'(root);
            end
            write_regs(count, stride);

            fill      = (n < REFILL_MAX) ? n : REFILL_MAX;
            scrambled = ($urandom_range(4) == 0);
            k         = int'($urandom) >>> 2;
            for (int i = 0; i < fill; i++) begin
                if (scrambled) begin
                    k = $urandom_range(16);
                    push_request(MODE_LOAD, SLOT_W'(i), k - 8);
                end else begin
                    push_request(MODE_LOAD, SLOT_W'(i), k);
                    k = k + (($urandom_range(2) == 0) ? 0 : $urandom_range(50, 1));
                end
            end
            repeat ($urandom_range(24, 10)) begin
                if ($urandom_range(9) == 0)
                    push_request(MODE_LOAD, SLOT_W'($urandom), $urandom);
                else
                    random_query(n);
            end
            phase++;
        end

        s_tvalid <= 1'b0;
        drain();
        $display("ran %0d loads and %0d searches over %0d register settings",
                 loads, queries, settings);
        $display("counts from empty to beyond the table, strides from zero to the widest");
        if (mismatches == 0 && awaited == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sorted_table_key_search.f =====
+incdir+rtl/core
rtl/core/stks_pkg.sv
rtl/core/stks_ram.sv
rtl/core/stks_ctrl.sv
rtl/core/stks_dp.sv
rtl/core/sorted_table_key_search.sv
bench/stks_search_checker.sv
bench/tb_sorted_table_key_search.sv
